// ===== sv/tcl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the command line parser: beat formats,
// result kinds, command keywords and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

	// result kinds reported on the result channel
	typedef enum logic [3:0] {
		KIND_QUIT         = 4'd0,
		KIND_LIST         = 4'd1,
		KIND_INFO         = 4'd2,
		KIND_SEARCH       = 4'd3,
		KIND_NUL          = 4'd4,
		KIND_LINE_LONG    = 4'd5,
		KIND_TOO_MANY     = 4'd6,
		KIND_TOKEN_LONG   = 4'd7,
		KIND_USAGE_QUIT   = 4'd8,
		KIND_USAGE_LIST   = 4'd9,
		KIND_USAGE_INFO   = 4'd10,
		KIND_USAGE_SEARCH = 4'd11,
		KIND_COUNT_LOW    = 4'd12,
		KIND_COUNT_BIG    = 4'd13,
		KIND_UNKNOWN      = 4'd14
	} kind_t;

	// input beat: one stream byte or a session restart
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} cmd_t;

	// result beat
	typedef struct packed {
		kind_t       result_kind;
		logic [30:0] request_id;
		logic [15:0] request_count;
	} res_t;

	// keywords, packed right aligned as the first token is shifted in
	localparam logic [47:0] TXT_QUIT   = 48'h0000_5155_4954;
	localparam logic [47:0] TXT_LIST   = 48'h0000_4C49_5354;
	localparam logic [47:0] TXT_INFO   = 48'h0000_494E_464F;
	localparam logic [47:0] TXT_SEARCH = 48'h5345_4152_4348;

	// special bytes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// magnitude saturation point and signed 32-bit limits
	localparam logic [31:0] MAG_CAP = 32'h8000_0001;
	localparam logic [31:0] MAG_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] MAG_NEG = 32'h8000_0000;

	// register map
	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_MAX_COUNT = 1'b0;
	localparam logic [15:0] MAX_COUNT_RESET = 16'd1000;

endpackage

`default_nettype wire

// ===== sv/text_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// text_command_line_parser
// Frames a byte stream into lines and decodes QUIT, LIST, INFO and SEARCH.
// ----------------------------------------------------------------------------
// One byte beat is taken per clock cycle while the input is not stalled. A
// beat goes into an input register, and from there the line state (length,
// token counters, keyword shift register and the two decimal accumulators)
// is updated in a single pass, with a multiply by ten as the longest path; a
// newline, a NUL byte or an overlong line loads at most one result beat into
// the result register. The input side only stalls when the result register
// is full, not taken, and the pending byte gives a result. After reset the
// block is ready at once; max_result_count resets to 1000 and is written
// through the APB port at address 0.
`default_nettype none

module text_command_line_parser #(
	parameter int unsigned LINE_MAX  = 256,
	parameter int unsigned TOKEN_MAX = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// byte channel
	input  wire logic                      cmd_valid,
	output      logic                      cmd_ready,
	input  wire tcl_pkg::cmd_t             cmd,
	// result channel
	output      logic                      res_valid,
	input  wire logic                      res_ready,
	output      tcl_pkg::res_t             res,
	// register port
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [tcl_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output      logic [31:0]               prdata,
	output      logic                      pready
);

	import tcl_pkg::*;

	localparam int unsigned LC_W = $clog2(LINE_MAX);
	localparam int unsigned TC_W = $clog2(TOKEN_MAX + 1);
	localparam logic [LC_W-1:0] LC_LAST = LC_W'(LINE_MAX - 1);
	localparam logic [TC_W-1:0] TC_SAT  = TC_W'(TOKEN_MAX);
	localparam logic [TC_W-1:0] TC_TEXT = TC_W'(6);

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_ARGS,
		PEND_TOKEN
	} pend_t;

	// decimal argument accumulator
	typedef struct packed {
		logic [31:0] mag;
		logic        neg;
		logic        digit;
		logic        bad;
	} num_t;

	// per-line token tracking
	typedef struct packed {
		logic [2:0]      tokens;
		logic            in_word;
		logic [TC_W-1:0] chars;
		logic [47:0]     text;
		pend_t           pend;
	} tok_t;

	// one character into a decimal accumulator
	function automatic num_t num_char(num_t n, logic first, logic [7:0] b);
		logic [35:0] m;
		num_t        r;
		r = n;
		m = '0;
		if (first && (b == CH_PLUS || b == CH_MINUS)) begin
			if (b == CH_MINUS)
				r.neg = 1'b1;
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			m = ({4'b0, n.mag} << 3) + ({4'b0, n.mag} << 1) + 36'(b - CH_ZERO);
			r.mag = (m > {4'b0, MAG_CAP}) ? MAG_CAP : m[31:0];
			r.digit = 1'b1;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

	function automatic logic num_ok(num_t n);
		return n.digit && !n.bad && (n.neg ? (n.mag <= MAG_NEG) : (n.mag <= MAG_POS));
	endfunction

	function automatic logic num_pos(num_t n);
		return !n.neg && (n.mag != '0);
	endfunction

	// register port
	logic [15:0] max_count_q;
	logic        reg_hit;

	assign reg_hit = (paddr[ADDR_W-1:2] == REG_MAX_COUNT);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {16'b0, max_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= MAX_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			max_count_q <= pwdata[15:0];
		end
	end

	// input register
	logic cmd_valid_s1;
	cmd_t cmd_s1;
	logic proceed;

	assign cmd_ready = !cmd_valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid)
			cmd_s1 <= cmd;
	end

	// parser state
	logic            discard_q, closed_q;
	logic [LC_W-1:0] line_count_q;
	tok_t            tok_q;
	num_t            arg1_q, arg2_q;

	logic            discard_nx, closed_nx;
	logic [LC_W-1:0] line_count_nx;
	tok_t            tok_nx, tok_et, tok_fd;
	num_t            arg1_nx, arg2_nx;
	logic            emit;
	res_t            res_nx;
	logic [7:0]      b;
	logic            blank;

	assign b     = cmd_s1.data_byte;
	assign blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);

	// token state after closing the current token
	always_comb begin
		tok_et = tok_q;
		if (tok_q.in_word && tok_q.pend == PEND_NONE) begin
			tok_et.in_word = 1'b0;
			if (tok_q.chars >= TC_SAT) begin
				tok_et.pend = PEND_TOKEN;
			end else begin
				if (tok_q.tokens == 3'd0 && tok_q.chars > TC_TEXT)
					tok_et.text = '0;
				tok_et.tokens = tok_q.tokens + 3'd1;
				if (tok_q.tokens >= 3'd3)
					tok_et.pend = PEND_ARGS;
			end
			tok_et.chars = '0;
		end
	end

	// token state after taking a non-blank character
	always_comb begin
		tok_fd = tok_q;
		if (!tok_fd.in_word) begin
			tok_fd.in_word = 1'b1;
			tok_fd.chars   = '0;
		end
		if (tok_fd.tokens == 3'd0 && tok_fd.chars < TC_TEXT)
			tok_fd.text = {tok_fd.text[39:0], b};
		if (tok_fd.chars < TC_SAT)
			tok_fd.chars = tok_fd.chars + 1'b1;
	end

	// per-beat update and result decode
	always_comb begin
		discard_nx    = discard_q;
		closed_nx     = closed_q;
		line_count_nx = line_count_q;
		tok_nx        = tok_q;
		arg1_nx       = arg1_q;
		arg2_nx       = arg2_q;
		emit          = 1'b0;
		res_nx        = '{result_kind: KIND_QUIT, request_id: '0, request_count: '0};

		priority if (cmd_s1.restart) begin
			discard_nx    = 1'b0;
			closed_nx     = 1'b0;
			line_count_nx = '0;
			tok_nx        = '0;
			arg1_nx       = '0;
			arg2_nx       = '0;
		end else if (closed_q) begin
			// session over, ignore everything
		end else if (discard_q) begin
			if (b == CH_NL)
				discard_nx = 1'b0;
		end else if (b == CH_NUL) begin
			discard_nx    = 1'b1;
			line_count_nx = '0;
			tok_nx        = '0;
			arg1_nx       = '0;
			arg2_nx       = '0;
			emit          = 1'b1;
			res_nx.result_kind = KIND_NUL;
		end else if (b == CH_NL) begin
			line_count_nx = '0;
			tok_nx        = '0;
			arg1_nx       = '0;
			arg2_nx       = '0;
			emit          = 1'b1;
			priority if (tok_et.pend == PEND_ARGS) begin
				res_nx.result_kind = KIND_TOO_MANY;
			end else if (tok_et.pend == PEND_TOKEN) begin
				res_nx.result_kind = KIND_TOKEN_LONG;
			end else if (tok_et.tokens == 3'd0) begin
				emit = 1'b0;
			end else if (tok_et.text == TXT_QUIT) begin
				if (tok_et.tokens != 3'd1) begin
					res_nx.result_kind = KIND_USAGE_QUIT;
				end else begin
					res_nx.result_kind = KIND_QUIT;
					closed_nx = 1'b1;
				end
			end else if (tok_et.text == TXT_LIST) begin
				res_nx.result_kind = (tok_et.tokens == 3'd1) ? KIND_LIST : KIND_USAGE_LIST;
			end else if (tok_et.text == TXT_INFO) begin
				if (tok_et.tokens != 3'd2 || !num_ok(arg1_q) || !num_pos(arg1_q)) begin
					res_nx.result_kind = KIND_USAGE_INFO;
				end else begin
					res_nx.result_kind = KIND_INFO;
					res_nx.request_id  = arg1_q.mag[30:0];
				end
			end else if (tok_et.text == TXT_SEARCH) begin
				priority if (tok_et.tokens != 3'd3 || !num_ok(arg1_q) || !num_pos(arg1_q)
						|| !num_ok(arg2_q)) begin
					res_nx.result_kind = KIND_USAGE_SEARCH;
				end else if (!num_pos(arg2_q)) begin
					res_nx.result_kind = KIND_COUNT_LOW;
				end else if (arg2_q.mag > {16'b0, max_count_q}) begin
					res_nx.result_kind = KIND_COUNT_BIG;
				end else begin
					res_nx.result_kind   = KIND_SEARCH;
					res_nx.request_id    = arg1_q.mag[30:0];
					res_nx.request_count = arg2_q.mag[15:0];
				end
			end else begin
				res_nx.result_kind = KIND_UNKNOWN;
			end
		end else if (line_count_q >= LC_LAST) begin
			discard_nx    = 1'b1;
			line_count_nx = '0;
			tok_nx        = '0;
			arg1_nx       = '0;
			arg2_nx       = '0;
			emit          = 1'b1;
			res_nx.result_kind = KIND_LINE_LONG;
		end else begin
			line_count_nx = line_count_q + 1'b1;
			if (tok_q.pend == PEND_NONE) begin
				if (blank) begin
					tok_nx = tok_et;
				end else begin
					tok_nx = tok_fd;
					// arguments accumulate unless the character went into the keyword
					if (!(tok_q.tokens == 3'd0 && (tok_q.in_word ? tok_q.chars : '0) < TC_TEXT)) begin
						if (tok_q.tokens == 3'd1)
							arg1_nx = num_char(arg1_q, !tok_q.in_word || tok_q.chars == '0, b);
						else if (tok_q.tokens == 3'd2)
							arg2_nx = num_char(arg2_q, !tok_q.in_word || tok_q.chars == '0, b);
					end
				end
			end
		end
	end

	// a byte moves on unless it has a result and the result register is blocked
	logic res_valid_q;
	res_t res_q;

	assign proceed   = cmd_valid_s1 && (!emit || !res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// state registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_q    <= 1'b0;
			closed_q     <= 1'b0;
			line_count_q <= '0;
			tok_q        <= '0;
			arg1_q       <= '0;
			arg2_q       <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;
			if (proceed) begin
				discard_q    <= discard_nx;
				closed_q     <= closed_nx;
				line_count_q <= line_count_nx;
				tok_q        <= tok_nx;
				arg1_q       <= arg1_nx;
				arg2_q       <= arg2_nx;
				if (emit)
					res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && emit)
			res_q <= res_nx;
	end

endmodule

`default_nettype wire

// ===== sv/tcl_checker.sv =====
// ----------------------------------------------------------------------------
// tcl_checker
// Port-level checks of the command line parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire tcl_pkg::res_t res
);

	import tcl_pkg::*;

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// only info and search carry an id
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind != KIND_INFO && res.result_kind != KIND_SEARCH
		|-> res.request_id == '0)
		else $error("id set on a kind without one");

	// only search carries a count
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind != KIND_SEARCH |-> res.request_count == '0)
		else $error("count set on a kind without one");

	// a good request has a positive id, and search a positive count
	a_req_positive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.result_kind == KIND_INFO || res.result_kind == KIND_SEARCH)
		|-> res.request_id != '0
			&& (res.result_kind == KIND_INFO || res.request_count != '0))
		else $error("request with zero id or count");

endmodule

bind text_command_line_parser tcl_checker u_tcl_checker (.*);

`default_nettype wire

// ===== tb/tb_text_command_line_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_command_line_parser
// Self-checking bench for the command line parser. A queue of byte beats,
// built from directed lines and from random commands, noise and broken
// lines, is driven with random gaps. A cycle-free predictor produces the
// expected result beats, and a monitor compares every result beat field by
// field. The result limit register is rewritten between phases while the
// block is idle, and read back.
// ----------------------------------------------------------------------------

module tb_text_command_line_parser;
	import tcl_pkg::*;

	localparam int LINE_LIMIT      = 256;
	localparam int TOKEN_LIMIT     = 64;
	localparam int SETTLE_CYCLES   = 10;
	localparam int ITEMS_PER_PHASE = 380;
	localparam int PHASES          = 5;
	localparam logic [ADDR_W-1:0] REG_ADDR = {REG_MAX_COUNT, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_ready;
	cmd_t               cmd;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	text_command_line_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// beats waiting to be driven and results still owed by the block
	cmd_t byte_q[$];
	res_t reply_q[$];
	res_t expected_reply;
	int   mismatch_count = 0;
	int   stim_count;
	bit   cmd_fire;
	bit   tx_steady;
	bit   rx_steady;
	int   tx_gap;
	int   rx_hold;

	// parser state mirror
	logic [15:0] count_limit;
	bit          discarding;
	bit          closed;
	int          line_len;
	int          tok_num;
	int          tok_len;
	bit          in_tok;
	logic [47:0] head_text;
	bit          err_hit;
	kind_t       err_kind;
	logic [32:0] arg_mag [2];
	bit          arg_neg [2];
	bit          arg_dig [2];
	bit          arg_bad [2];

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// line state predictor
	// ------------------------------------------------------------------

	function automatic void clear_line_state();
		line_len  = 0;
		tok_num   = 0;
		tok_len   = 0;
		in_tok    = 1'b0;
		head_text = '0;
		err_hit   = 1'b0;
		err_kind  = KIND_QUIT;
		for (int a = 0; a < 2; a++) begin
			arg_mag[a] = '0;
			arg_neg[a] = 1'b0;
			arg_dig[a] = 1'b0;
			arg_bad[a] = 1'b0;
		end
	endfunction

	function automatic bit is_space(logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	// decimal accumulation with sign and saturation
	function automatic void add_arg_char(int a, logic [7:0] b);
		logic [35:0] m;
		if (tok_len == 0 && (b == CH_PLUS || b == CH_MINUS)) begin
			if (b == CH_MINUS)
				arg_neg[a] = 1'b1;
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			m = arg_mag[a] * 36'd10 + 36'(b - CH_ZERO);
			arg_mag[a] = (m > 36'(MAG_CAP)) ? 33'(MAG_CAP) : m[32:0];
			arg_dig[a] = 1'b1;
		end else begin
			arg_bad[a] = 1'b1;
		end
	endfunction

	function automatic bit arg_ok(int a);
		if (!arg_dig[a] || arg_bad[a])
			return 1'b0;
		return arg_neg[a] ? (arg_mag[a] <= 33'(MAG_NEG)) : (arg_mag[a] <= 33'(MAG_POS));
	endfunction

	function automatic bit arg_pos(int a);
		return !arg_neg[a] && arg_mag[a] != 0;
	endfunction

	// token end: first error wins
	function automatic void close_token();
		if (!in_tok || err_hit)
			return;
		in_tok = 1'b0;
		if (tok_len >= TOKEN_LIMIT) begin
			err_hit  = 1'b1;
			err_kind = KIND_TOKEN_LONG;
		end else begin
			if (tok_num == 0 && tok_len > 6)
				head_text = '0;
			tok_num++;
			if (tok_num >= 4) begin
				err_hit  = 1'b1;
				err_kind = KIND_TOO_MANY;
			end
		end
		tok_len = 0;
	endfunction

	function automatic void take_char(logic [7:0] b);
		if (err_hit)
			return;
		if (is_space(b)) begin
			close_token();
			return;
		end
		if (!in_tok) begin
			in_tok  = 1'b1;
			tok_len = 0;
		end
		if (tok_num == 0 && tok_len < 6)
			head_text = {head_text[39:0], b};
		else if (tok_num == 1)
			add_arg_char(0, b);
		else if (tok_num == 2)
			add_arg_char(1, b);
		if (tok_len < TOKEN_LIMIT)
			tok_len++;
	endfunction

	function automatic void push_reply(kind_t k, logic [30:0] id, logic [15:0] n);
		res_t r;
		r.result_kind   = k;
		r.request_id    = id;
		r.request_count = n;
		reply_q.push_back(r);
	endfunction

	// newline: decode the finished line
	function automatic void end_line();
		close_token();
		if (err_hit) begin
			push_reply(err_kind, '0, '0);
		end else if (tok_num != 0) begin
			if (head_text == TXT_QUIT) begin
				if (tok_num != 1) begin
					push_reply(KIND_USAGE_QUIT, '0, '0);
				end else begin
					closed = 1'b1;
					push_reply(KIND_QUIT, '0, '0);
				end
			end else if (head_text == TXT_LIST) begin
				push_reply((tok_num == 1) ? KIND_LIST : KIND_USAGE_LIST, '0, '0);
			end else if (head_text == TXT_INFO) begin
				if (tok_num != 2 || !arg_ok(0) || !arg_pos(0))
					push_reply(KIND_USAGE_INFO, '0, '0);
				else
					push_reply(KIND_INFO, arg_mag[0][30:0], '0);
			end else if (head_text == TXT_SEARCH) begin
				if (tok_num != 3 || !arg_ok(0) || !arg_pos(0) || !arg_ok(1))
					push_reply(KIND_USAGE_SEARCH, '0, '0);
				else if (!arg_pos(1))
					push_reply(KIND_COUNT_LOW, '0, '0);
				else if (arg_mag[1] > 33'(count_limit))
					push_reply(KIND_COUNT_BIG, '0, '0);
				else
					push_reply(KIND_SEARCH, arg_mag[0][30:0], arg_mag[1][15:0]);
			end else begin
				push_reply(KIND_UNKNOWN, '0, '0);
			end
		end
		clear_line_state();
	endfunction

	function automatic void predict_beat(cmd_t c);
		if (c.restart) begin
			discarding = 1'b0;
			closed     = 1'b0;
			clear_line_state();
		end else if (!closed) begin
			if (discarding) begin
				if (c.data_byte == CH_NL)
					discarding = 1'b0;
			end else if (c.data_byte == CH_NUL) begin
				clear_line_state();
				discarding = 1'b1;
				push_reply(KIND_NUL, '0, '0);
			end else if (c.data_byte == CH_NL) begin
				end_line();
			end else if (line_len >= LINE_LIMIT - 1) begin
				clear_line_state();
				discarding = 1'b1;
				push_reply(KIND_LINE_LONG, '0, '0);
			end else begin
				line_len++;
				take_char(c.data_byte);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------

	function automatic void send_byte(logic [7:0] b, bit counted = 1'b1);
		cmd_t c;
		c.data_byte = b;
		c.restart   = 1'b0;
		byte_q.push_back(c);
		if (counted)
			stim_count++;
	endfunction

	function automatic void send_text(string s);
		foreach (s[i])
			send_byte(s[i]);
	endfunction

	function automatic void send_restart();
		cmd_t c;
		c.data_byte = 8'($urandom);
		c.restart   = 1'b1;
		byte_q.push_back(c);
		stim_count++;
	endfunction

	function automatic string blank_run();
		string s;
		int n;
		s = "";
		n = $urandom_range(1, 3);
		repeat (n)
			case ($urandom_range(0, 5))
				0: s = {s, "\011"};
				1: s = {s, "\013"};
				2: s = {s, "\014"};
				3: s = {s, "\015"};
				default: s = {s, " "};
			endcase
		return s;
	endfunction

	function automatic string rand_word(int len);
		string s;
		s = "";
		repeat (len)
			s = {s, $sformatf("%c", $urandom_range(33, 126))};
		return s;
	endfunction

	function automatic string num_text(longint v);
		string digits;
		int r;
		digits = $sformatf("%0d", (v < 0) ? -v : v);
		r = $urandom_range(0, 7);
		if (r == 1)
			digits = {"00", digits};
		if (v < 0)
			return {"-", digits};
		if (r == 0)
			return {"+", digits};
		return digits;
	endfunction

	// numbers that are malformed or sit on a range edge
	function automatic string odd_num();
		case ($urandom_range(0, 6))
			0: return "-";
			1: return "+";
			2: return $sformatf("%0da", $urandom_range(0, 999));
			3: return "1-2";
			4: return "--3";
			5: return "-0";
			default: return "99999999999999999999";
		endcase
	endfunction

	function automatic longint pick_id();
		case ($urandom_range(0, 11))
			0: return 1;
			1: return 64'sd2147483647;
			2: return 64'sd2147483648;
			3: return 0;
			4: return -1;
			5: return -64'sd2147483648;
			6: return -64'sd2147483649;
			7: return 64'sd99999999999;
			8: return longint'($urandom_range(1, 32'h7FFF_FFFF));
			default: return longint'($urandom_range(1, 1000000));
		endcase
	endfunction

	function automatic longint pick_count();
		longint top;
		top = longint'(count_limit);
		case ($urandom_range(0, 9))
			0: return 1;
			1: return top;
			2: return top + 1;
			3: return 0;
			4: return -longint'($urandom_range(1, 100));
			5: return 65536;
			6: return 64'sd2147483648;
			default: return longint'($urandom_range(1, int'(top) + 1));
		endcase
	endfunction

	function automatic string arg_text(bit is_count);
		if ($urandom_range(0, 6) == 0)
			return odd_num();
		return num_text(is_count ? pick_count() : pick_id());
	endfunction

	// words joined by blank runs, optional leading and trailing blanks
	function automatic void send_line(string w[$]);
		if ($urandom_range(0, 3) == 0)
			send_text(blank_run());
		foreach (w[i]) begin
			if (i != 0)
				send_text(blank_run());
			send_text(w[i]);
		end
		if ($urandom_range(0, 3) == 0)
			send_text(blank_run());
		send_byte(CH_NL);
	endfunction

	// keyword line padded with blanks to a given length before the newline
	function automatic void send_padded(string head, int len);
		send_text(head);
		repeat (len - head.len())
			send_byte(CH_SPACE);
		send_byte(CH_NL);
	endfunction

	function automatic void make_line();
		string w[$];
		int r;
		int n;
		int len;
		int pos;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			w.push_back("LIST");
			if ($urandom_range(0, 4) == 0)
				w.push_back(arg_text(1'b0));
			send_line(w);
		end else if (r < 28) begin
			w.push_back("INFO");
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 1;
			repeat (n)
				w.push_back(arg_text(1'b0));
			send_line(w);
		end else if (r < 56) begin
			w.push_back("SEARCH");
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 2;
			for (int i = 0; i < n; i++)
				w.push_back(arg_text(i == 1));
			send_line(w);
		end else if (r < 60) begin
			// good quit, ignored tail, then a new session
			w.push_back("QUIT");
			send_line(w);
			n = $urandom_range(0, 6);
			repeat (n)
				send_byte(8'($urandom), 1'b0);
			send_restart();
		end else if (r < 63) begin
			w.push_back("QUIT");
			w.push_back(arg_text(1'b0));
			send_line(w);
		end else if (r < 67) begin
			case ($urandom_range(0, 2))
				0: w.push_back("LIST");
				1: w.push_back("SEARCH");
				default: w.push_back(rand_word($urandom_range(1, 8)));
			endcase
			n = $urandom_range(3, 5);
			repeat (n)
				w.push_back(num_text(pick_id()));
			send_line(w);
		end else if (r < 72) begin
			// long token, near or over the token limit, somewhere in a search line
			case ($urandom_range(0, 3))
				0: len = TOKEN_LIMIT - 1;
				1: len = TOKEN_LIMIT;
				2: len = TOKEN_LIMIT + 1;
				default: len = $urandom_range(7, 100);
			endcase
			w.push_back("SEARCH");
			w.push_back("5");
			w.push_back("7");
			pos = $urandom_range(0, 3);
			if (pos == 3)
				w.push_back(rand_word(len));
			else
				w[pos] = rand_word(len);
			send_line(w);
		end else if (r < 73) begin
			n = $urandom_range(250, 262);
			repeat (n)
				send_byte(($urandom_range(0, 4) == 0) ? CH_SPACE : 8'($urandom_range(33, 126)));
			send_byte(CH_NL);
		end else if (r < 78) begin
			// nul inside a line, more nul bytes while discarding
			send_text(($urandom_range(0, 1) == 0) ? "SEARCH 12" : rand_word($urandom_range(0, 5)));
			send_byte(CH_NUL);
			n = $urandom_range(0, 6);
			repeat (n)
				send_byte(($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
			send_byte(CH_NL);
		end else if (r < 83) begin
			send_line(w);
		end else if (r < 89) begin
			case ($urandom_range(0, 7))
				0: w.push_back("quit");
				1: w.push_back("list");
				2: w.push_back("SEARCHX");
				3: w.push_back("LISTS");
				4: w.push_back("INF");
				5: w.push_back("QUITQUIT");
				6: w.push_back("SEARC");
				default: w.push_back(rand_word($urandom_range(1, 8)));
			endcase
			if ($urandom_range(0, 1) == 0)
				w.push_back(arg_text(1'b0));
			send_line(w);
		end else if (r < 95) begin
			n = $urandom_range(1, 20);
			repeat (n)
				send_byte(8'($urandom_range(0, 255)));
			send_byte(CH_NL);
		end else begin
			// restart in the middle of a line or of a discard
			if ($urandom_range(0, 2) == 0)
				send_byte(CH_NUL);
			send_text(($urandom_range(0, 1) == 0) ? "SEARCH 4" : rand_word($urandom_range(0, 6)));
			send_restart();
		end
	endfunction

	// ------------------------------------------------------------------
	// beat driver, result monitor, receiver
	// ------------------------------------------------------------------

	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// byte driver: next beat once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_fire) begin
			if ($urandom_range(0, 149) == 0)
				tx_steady = !tx_steady;
			if (tx_gap > 0) begin
				cmd_valid <= 1'b0;
				tx_gap--;
			end else if (byte_q.size() != 0) begin
				cmd       <= byte_q.pop_front();
				cmd_valid <= 1'b1;
				tx_gap = pick_gap(tx_steady);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 149) == 0)
				rx_steady = !rx_steady;
			if (rx_hold > 0) begin
				res_ready <= 1'b0;
				rx_hold--;
			end else begin
				res_ready <= 1'b1;
				rx_hold = pick_gap(rx_steady);
			end
		end
	end

	// check result beats, then predict from the accepted byte beat
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_fire <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (reply_q.size() == 0) begin
					$error("unexpected result beat: result_kind %0d", res.result_kind);
					mismatch_count++;
				end else begin
					expected_reply = reply_q.pop_front();
					if (res.result_kind !== expected_reply.result_kind) begin
						$error("result_kind: expected %0d, actual %0d",
							expected_reply.result_kind, res.result_kind);
						mismatch_count++;
					end
					if (res.request_id !== expected_reply.request_id) begin
						$error("request_id: expected %0d, actual %0d",
							expected_reply.request_id, res.request_id);
						mismatch_count++;
					end
					if (res.request_count !== expected_reply.request_count) begin
						$error("request_count: expected %0d, actual %0d",
							expected_reply.request_count, res.request_count);
						mismatch_count++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				predict_beat(cmd);
			cmd_fire <= cmd_valid && cmd_ready;
		end
	end

	// ------------------------------------------------------------------
	// register access and idle wait
	// ------------------------------------------------------------------

	// write then read back the result limit register
	task automatic write_limit(logic [15:0] v);
		logic [31:0] word;
		word       = $urandom;
		word[15:0] = v;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		count_limit = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {16'h0000, v}) begin
			$error("max_result_count: expected %0d, actual %0d", v, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// hold off until every byte beat is taken and every result has come
	task automatic drain();
		bit idle;
		idle = 1'b0;
		while (!idle) begin
			@(posedge clk);
			idle = byte_q.size() == 0 && !cmd_valid;
			@(negedge clk);
			idle = idle && reply_q.size() == 0;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		res_ready = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		tx_gap    = 0;
		rx_hold   = 0;
		count_limit = MAX_COUNT_RESET;
		discarding  = 1'b0;
		closed      = 1'b0;
		clear_line_state();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: trailing carriage return, nul while discarding, info, quit
		send_text("LIST\015\n");
		send_byte(CH_NUL);
		send_byte(CH_NUL);
		send_text("x\n");
		send_text("INFO 9\n");
		send_text("QUIT\n");
		send_byte("L", 1'b0);
		send_restart();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				drain();
				case (phase)
					1: write_limit(16'd1);
					2: write_limit(16'hFFFF);
					3: write_limit(16'd0);
					default: write_limit(16'($urandom_range(2, 65534)));
				endcase
			end
			stim_count = 0;
			// one line on each side of the length limit, one erroring before it
			case (phase)
				1: send_padded("LIST", LINE_LIMIT - 1);
				2: send_padded("LIST", LINE_LIMIT);
				3: send_padded("LIST 1 2 3 4", LINE_LIMIT + 40);
				default: ;
			endcase
			while (stim_count < ITEMS_PER_PHASE)
				make_line();
		end

		drain();
		if (mismatch_count == 0 && reply_q.size() == 0)
			$display("[text_command_line_parser] OK");
		else
			$display("[text_command_line_parser] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("[text_command_line_parser] ERROR");
		$finish;
	end

endmodule
